### rtl/atp_pkg.sv
// Package for the accelerator task placement engine: word types, codes,
// table sizes and widths. Used by every module under rtl.
package atp_pkg;

    localparam int DEVICE_SLOTS  = 8;
    localparam int GRANT_ENTRIES = 16;
    localparam int SLOT_W        = 3;
    localparam int GRANT_W       = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_DEVICE  = 2'd1;
    localparam logic [1:0] FUNC_HOST    = 2'd2;
    localparam logic [1:0] FUNC_REQUEST = 2'd3;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_HOST_MEM = 3'd1;
    localparam logic [2:0] ST_HOST_LD  = 3'd2;
    localparam logic [2:0] ST_NO_DEV   = 3'd3;
    localparam logic [2:0] ST_ACK      = 3'd4;

    localparam logic [1:0] REG_HOST_RSV = 2'd0;
    localparam logic [1:0] REG_DEV_RSV  = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_CPU_CNT  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  slot;
        logic [7:0]  dev_ident;
        logic [19:0] total_mem;
        logic [19:0] free_mem;
        logic [6:0]  load_pct;
        logic [19:0] req_host_mem;
        logic [19:0] req_device_mem;
        logic [14:0] req_cpu_load;
        logic [6:0]  req_device_load;
        logic        force_req;
        logic [7:0]  device_mask;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] chosen_device;
        logic       grants_full;
    } out_word_t;

    typedef struct packed {
        logic [19:0] host_mem_reserve;
        logic [19:0] device_mem_reserve;
        logic [15:0] grant_lifetime;
        logic [7:0]  cpu_count;
    } cfg_t;

endpackage

### rtl/accelerator_task_placement.sv
// Top level of the accelerator task placement engine.
// Depends on atp_pkg, atp_front, atp_back.
//
// Input words are pushed while full is low; results are taken by pop
// while empty is low, one result word per input word, in order.
// The front holds a two-word queue, so pushes go on while a result waits.
// A queued word reaches the idle back end in the cycle after its push.
// In the back end a status word only updates the tables, and a tick walks
// the 16-entry grant table. A request walks the grants for host sums, then
// for each masked present device walks the grants and checks it and, when
// it passes, runs a bit-serial divide for the memory ratio; it then scans
// for a free grant entry. The shortest request is a host refusal, the
// longest one with all eight devices scored.
// Reset empties the queue, clears device presence, host figures and all
// grants, and loads the registers with their reset values.
// If the receiver stalls, the finished result is held and the back end
// waits once it has a second one; the front queue then fills and full rises.
// Registers at paddr 0,4,8,12: host reserve, device reserve, lifetime,
// cpu count.
module accelerator_task_placement
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  atp_pkg::in_word_t  in_word,
    output logic               empty,
    input  logic               pop,
    output atp_pkg::out_word_t out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import atp_pkg::*;

    logic     q_valid, q_take;
    in_word_t q_word;
    cfg_t     cfg;

    assign pready = 1'b1;

    atp_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );

    atp_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_word(q_word), .cfg(cfg), .empty(empty), .pop(pop),
        .out_word(out_word)
    );

endmodule

### rtl/atp_front.sv
// Front end: input queue of depth QUEUE_DEPTH plus configuration registers.
// Depends on atp_pkg.
module atp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  atp_pkg::in_word_t in_word,
    output logic              q_valid,
    input  logic              q_take,
    output atp_pkg::in_word_t q_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output atp_pkg::cfg_t     cfg
);
    import atp_pkg::*;

    in_word_t   mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cfg_t       cfg_reg;
    logic       do_push, do_pop, wr_en;

    assign full    = (cnt_reg == 2'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // store words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= in_word;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wp_reg <= !wp_reg;
            if (do_pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.host_mem_reserve   <= 20'd0;
            cfg_reg.device_mem_reserve <= 20'd0;
            cfg_reg.grant_lifetime     <= 16'd10;
            cfg_reg.cpu_count          <= 8'd1;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_HOST_RSV: cfg_reg.host_mem_reserve   <= pwdata[19:0];
                REG_DEV_RSV:  cfg_reg.device_mem_reserve <= pwdata[19:0];
                REG_LIFETIME: cfg_reg.grant_lifetime     <= pwdata[15:0];
                REG_CPU_CNT:  cfg_reg.cpu_count          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_HOST_RSV: prdata = {12'd0, cfg_reg.host_mem_reserve};
            REG_DEV_RSV:  prdata = {12'd0, cfg_reg.device_mem_reserve};
            REG_LIFETIME: prdata = {16'd0, cfg_reg.grant_lifetime};
            REG_CPU_CNT:  prdata = {24'd0, cfg_reg.cpu_count};
            default:      prdata = 32'd0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !do_pop) |=> full)
        else $error("queue lost a word");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!q_valid) |-> !do_pop)
        else $error("pop from empty queue");

endmodule

### rtl/atp_divider.sv
// Restoring divider, one quotient bit per cycle: 37-bit dividend by 20 bits.
// Depends on atp_pkg only for house style.
module atp_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [36:0] dividend,
    input  logic [19:0] divisor,
    output logic        busy,
    output logic [16:0] quotient
);
    import atp_pkg::*;

    logic [36:0] num_reg;
    logic [20:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [20:0] trial;
    logic [21:0] diff;

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = num_reg[16:0];
    assign trial    = {rem_reg[19:0], num_reg[36]};
    assign diff     = {1'b0, trial} - {2'b0, divisor};

    // shift one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
            num_reg <= 37'd0;
            rem_reg <= 21'd0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd37;
            num_reg <= dividend;
            rem_reg <= 21'd0;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (!diff[21])
            begin
                rem_reg <= diff[20:0];
                num_reg <= {num_reg[35:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[35:0], 1'b0};
            end
        end
    end

endmodule

### rtl/atp_back.sv
// Back end: state tables, grant walk, device scoring and result queue slot.
// Depends on atp_pkg and atp_divider.
module atp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  atp_pkg::in_word_t  q_word,
    input  atp_pkg::cfg_t      cfg,
    output logic               empty,
    input  logic               pop,
    output atp_pkg::out_word_t out_word
);
    import atp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_HSUM, S_HCHK, S_DINIT, S_DSUM, S_DCHK,
        S_DIV1, S_DIV2, S_PICK, S_FIND, S_DONE
    } state_t;

    state_t state_reg;
    in_word_t w_reg;
    logic [7:0]  dev_id   [DEVICE_SLOTS];
    logic [19:0] dev_tot  [DEVICE_SLOTS];
    logic [19:0] dev_free [DEVICE_SLOTS];
    logic [6:0]  dev_load [DEVICE_SLOTS];
    logic [DEVICE_SLOTS-1:0] dev_present_reg;
    logic [19:0] host_free_reg;
    logic [6:0]  host_load_reg;
    logic [GRANT_ENTRIES-1:0] gvalid_reg;
    logic [15:0] g_age  [GRANT_ENTRIES];
    logic [7:0]  g_dev  [GRANT_ENTRIES];
    logic [19:0] g_hm   [GRANT_ENTRIES];
    logic [19:0] g_dm   [GRANT_ENTRIES];
    logic [14:0] g_cpu  [GRANT_ENTRIES];
    logic [6:0]  g_dl   [GRANT_ENTRIES];

    logic [GRANT_W:0] gi_reg;
    logic [SLOT_W:0]  si_reg;
    logic [24:0] sum_hm_reg;
    logic [19:0] sum_cpu_reg;
    logic [25:0] free_adj_reg;   // signed
    logic [11:0] load_adj_reg;
    logic [19:0] fclip_reg;
    logic [16:0] ratio_reg;
    logic [17:0] best_score_reg;
    logic [SLOT_W-1:0] best_reg;
    logic        found_reg;
    out_word_t   acc_reg;
    out_word_t   res_reg;
    logic        full_reg;
    logic        div_start, div_busy;
    logic [36:0] div_num;
    logic [19:0] div_den;
    logic [16:0] div_q;

    logic [GRANT_W-1:0] gi;
    logic [SLOT_W-1:0]  si;
    logic signed [27:0] host_margin, dev_margin;
    logic signed [27:0] host_cap;
    logic signed [13:0] idle_s;
    logic [6:0]  idle_c;
    logic [17:0] idle_term, score;
    logic dev_ok;

    assign gi = gi_reg[GRANT_W-1:0];
    assign si = si_reg[SLOT_W-1:0];
    assign empty    = !full_reg;
    assign out_word = res_reg;
    assign q_take   = (state_reg == S_IDLE) && q_valid;

    atp_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(div_den), .busy(div_busy), .quotient(div_q)
    );

    // checks and score terms
    always_comb
    begin
        host_margin = 28'(signed'({1'b0, host_free_reg}))
            - 28'(signed'({1'b0, cfg.host_mem_reserve}))
            - 28'(signed'({1'b0, sum_hm_reg}))
            - 28'(signed'({1'b0, w_reg.req_host_mem}));
        host_cap = (28'sd100 - 28'(signed'({1'b0, host_load_reg})))
            * 28'(signed'({1'b0, ((cfg.cpu_count == 8'd0) ? 8'd1 : cfg.cpu_count)}));
        dev_margin = 28'(signed'(free_adj_reg))
            - 28'(signed'({1'b0, cfg.device_mem_reserve}))
            - 28'(signed'({1'b0, w_reg.req_device_mem}));
        idle_s = 14'sd100 - 14'(signed'({1'b0, load_adj_reg}));
        dev_ok = (dev_margin > 0) && (w_reg.force_req ||
            ((idle_s >= 14'sd10) &&
             (idle_s - 14'(signed'({1'b0, w_reg.req_device_load})) > 0)));
        idle_c = (idle_s < 0) ? 7'd0 : 7'(idle_s);
        // exact idle*131072/100 as idle*1310 + idle*18/25, the last by reciprocal
        idle_term = 18'(32'(idle_c) * 32'd1310) + 18'((32'(idle_c) * 32'd47196) >> 16);
        div_num = {fclip_reg, 17'd0} >> 1;
        div_den = dev_tot[si];
        score = 18'(ratio_reg) + idle_term;
    end

    assign div_start = (state_reg == S_DIV1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_word.func == FUNC_DEVICE)
        begin
            dev_id[q_word.slot]   <= q_word.dev_ident;
            dev_tot[q_word.slot]  <= q_word.total_mem;
            dev_free[q_word.slot] <= q_word.free_mem;
            dev_load[q_word.slot] <= q_word.load_pct;
        end
        if (state_reg == S_TICK && gvalid_reg[gi] && g_age[gi] < cfg.grant_lifetime)
            g_age[gi] <= g_age[gi] + 16'd1;
        if (state_reg == S_FIND && !gi_reg[GRANT_W] && !gvalid_reg[gi])
        begin
            g_age[gi] <= 16'd0;
            g_dev[gi] <= dev_id[best_reg];
            g_hm[gi]  <= w_reg.req_host_mem;
            g_dm[gi]  <= w_reg.req_device_mem;
            g_cpu[gi] <= w_reg.req_cpu_load;
            g_dl[gi]  <= w_reg.req_device_load;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dev_present_reg <= '0;
            host_free_reg <= 20'd0;
            host_load_reg <= 7'd0;
            gvalid_reg <= '0;
            full_reg <= 1'b0;
            acc_reg <= '0;
            res_reg <= '0;
            w_reg <= '0;
            gi_reg <= '0; si_reg <= '0;
            sum_hm_reg <= '0; sum_cpu_reg <= '0;
            free_adj_reg <= '0; load_adj_reg <= '0;
            fclip_reg <= '0; ratio_reg <= '0;
            best_score_reg <= '0; best_reg <= '0; found_reg <= 1'b0;
        end
        else
        begin
            if (pop && full_reg && state_reg != S_DONE) full_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        w_reg <= q_word;
                        gi_reg <= '0; si_reg <= '0;
                        sum_hm_reg <= '0; sum_cpu_reg <= '0;
                        found_reg <= 1'b0; best_score_reg <= '0;
                        acc_reg <= '{status: ST_ACK, chosen_device: 8'd0,
                                     grants_full: 1'b0};
                        case (q_word.func)
                            FUNC_TICK:   state_reg <= S_TICK;
                            FUNC_DEVICE:
                            begin
                                dev_present_reg[q_word.slot] <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            FUNC_HOST:
                            begin
                                host_free_reg <= q_word.free_mem;
                                host_load_reg <= q_word.load_pct;
                                state_reg <= S_DONE;
                            end
                            default:     state_reg <= S_HSUM;
                        endcase
                    end
                end
                S_TICK:
                begin
                    if (gvalid_reg[gi] && g_age[gi] >= cfg.grant_lifetime)
                        gvalid_reg[gi] <= 1'b0;
                    gi_reg <= gi_reg + 1'b1;
                    if (gi_reg == (GRANT_W+1)'(GRANT_ENTRIES - 1)) state_reg <= S_DONE;
                end
                S_HSUM:
                begin
                    if (gvalid_reg[gi])
                    begin
                        sum_hm_reg  <= sum_hm_reg + 25'(g_hm[gi]);
                        sum_cpu_reg <= sum_cpu_reg + 20'(g_cpu[gi]);
                    end
                    gi_reg <= gi_reg + 1'b1;
                    if (gi_reg == (GRANT_W+1)'(GRANT_ENTRIES - 1)) state_reg <= S_HCHK;
                end
                S_HCHK:
                begin
                    if (host_margin <= 0)
                    begin
                        acc_reg.status <= ST_HOST_MEM;
                        state_reg <= S_DONE;
                    end
                    else if (!w_reg.force_req &&
                             host_cap <= 28'(signed'({1'b0, sum_cpu_reg}))
                                       + 28'(signed'({1'b0, w_reg.req_cpu_load})))
                    begin
                        acc_reg.status <= ST_HOST_LD;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    if (si_reg[SLOT_W])
                        state_reg <= S_FIND;
                    else if (w_reg.device_mask[si] && dev_present_reg[si])
                    begin
                        free_adj_reg <= 26'(dev_free[si]);
                        load_adj_reg <= 12'(dev_load[si]);
                        state_reg <= S_DSUM;
                    end
                    else
                        si_reg <= si_reg + 1'b1;
                    gi_reg <= '0;
                end
                S_DSUM:
                begin
                    if (gvalid_reg[gi] && g_dev[gi] == dev_id[si])
                    begin
                        free_adj_reg <= free_adj_reg - 26'(g_dm[gi]);
                        load_adj_reg <= load_adj_reg + 12'(g_dl[gi]);
                    end
                    gi_reg <= gi_reg + 1'b1;
                    if (gi_reg == (GRANT_W+1)'(GRANT_ENTRIES - 1)) state_reg <= S_DCHK;
                end
                S_DCHK:
                begin
                    if (dev_ok)
                    begin
                        fclip_reg <= free_adj_reg[25] ? 20'd0 :
                            (free_adj_reg > 26'(dev_tot[si]) ? dev_tot[si]
                                                             : free_adj_reg[19:0]);
                        state_reg <= S_DIV1;
                    end
                    else
                    begin
                        si_reg <= si_reg + 1'b1;
                        state_reg <= S_DINIT;
                    end
                end
                S_DIV1: state_reg <= S_DIV2;
                S_DIV2:
                begin
                    if (!div_busy)
                    begin
                        ratio_reg <= (dev_tot[si] == 20'd0) ? 17'd0 : div_q;
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (!found_reg || score > best_score_reg)
                    begin
                        found_reg <= 1'b1;
                        best_reg <= si;
                        best_score_reg <= score;
                    end
                    si_reg <= si_reg + 1'b1;
                    state_reg <= S_DINIT;
                end
                S_FIND:
                begin
                    if (!found_reg)
                    begin
                        acc_reg.status <= ST_NO_DEV;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        acc_reg.status <= ST_GRANTED;
                        acc_reg.chosen_device <= dev_id[best_reg];
                        if (gi_reg[GRANT_W])
                        begin
                            acc_reg.grants_full <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else if (!gvalid_reg[gi])
                        begin
                            gvalid_reg[gi] <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                            gi_reg <= gi_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    // hand the finished word over once the result slot is free
                    if (!full_reg || pop)
                    begin
                        res_reg <= acc_reg;
                        full_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !full_reg) |=> !empty)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (state_reg == S_IDLE))
        else $error("take while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV1) |=> div_busy)
        else $error("divider did not start");

endmodule

### tb/sv/atp_checker.sv
// Checker for the accelerator task placement engine: watches the input,
// result and register channels, predicts each result word and compares.
// Depends on atp_pkg.
module atp_checker
    import atp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  in_word_t   in_word,
    input  logic       empty,
    input  logic       pop,
    input  out_word_t  out_word,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    input  logic       pready,
    output int         fail_count,
    output int         pending,
    output int         checked,
    output int         granted
);

    // shadow of the registers
    logic [19:0] host_rsv, dev_rsv;
    logic [15:0] lifetime;
    logic [7:0]  cpus;

    // shadow of the device table, host figures and grant table
    logic [7:0]  slot_id    [DEVICE_SLOTS];
    logic [19:0] slot_total [DEVICE_SLOTS];
    logic [19:0] slot_free  [DEVICE_SLOTS];
    logic [6:0]  slot_load  [DEVICE_SLOTS];
    logic        slot_here  [DEVICE_SLOTS];
    logic [19:0] host_free_mb;
    logic [6:0]  host_busy;
    logic        gr_live    [GRANT_ENTRIES];
    logic [15:0] gr_age     [GRANT_ENTRIES];
    logic [7:0]  gr_dev     [GRANT_ENTRIES];
    logic [19:0] gr_hmem    [GRANT_ENTRIES];
    logic [19:0] gr_dmem    [GRANT_ENTRIES];
    logic [14:0] gr_cpu     [GRANT_ENTRIES];
    logic [6:0]  gr_dload   [GRANT_ENTRIES];

    out_word_t placement_q[$];

    assign pending = placement_q.size();

    // Q2.16 score: free ratio plus idle share
    function automatic longint place_score(longint free_adj, longint total, longint load_adj);
        longint ratio;
        longint f;
        longint idle;
        ratio = 0;
        if (total > 0)
        begin
            f = free_adj < 0 ? 0 : (free_adj > total ? total : free_adj);
            ratio = (f * 65536) / total;
        end
        idle = 100 - load_adj;
        if (idle < 0) idle = 0;
        if (idle > 100) idle = 100;
        return ratio + (idle * 131072) / 100;
    endfunction

    // advance the shadow state by one input word and return its result
    function automatic out_word_t place_word(in_word_t w);
        out_word_t r;
        longint sum_hm;
        longint sum_cpu;
        longint c;
        longint fa;
        longint la;
        longint sc;
        longint best_sc;
        int best;
        int g;
        int free_g;
        r = '{status: ST_ACK, chosen_device: 8'd0, grants_full: 1'b0};
        case (w.func)
            FUNC_TICK:
            begin
                for (g = 0; g < GRANT_ENTRIES; g++)
                    if (gr_live[g])
                    begin
                        if (gr_age[g] >= lifetime) gr_live[g] = 1'b0;
                        else gr_age[g] = gr_age[g] + 16'd1;
                    end
            end
            FUNC_DEVICE:
            begin
                slot_id[w.slot]    = w.dev_ident;
                slot_total[w.slot] = w.total_mem;
                slot_free[w.slot]  = w.free_mem;
                slot_load[w.slot]  = w.load_pct;
                slot_here[w.slot]  = 1'b1;
            end
            FUNC_HOST:
            begin
                host_free_mb = w.free_mem;
                host_busy    = w.load_pct;
            end
            default:
            begin
                sum_hm = 0;
                sum_cpu = 0;
                c = (cpus == 0) ? 1 : longint'(cpus);
                for (g = 0; g < GRANT_ENTRIES; g++)
                    if (gr_live[g])
                    begin
                        sum_hm += gr_hmem[g];
                        sum_cpu += gr_cpu[g];
                    end
                if (longint'(host_free_mb) - longint'(host_rsv) - sum_hm
                    - longint'(w.req_host_mem) <= 0)
                begin
                    r.status = ST_HOST_MEM;
                    return r;
                end
                if (!w.force_req &&
                    (100 - longint'(host_busy)) * c <= sum_cpu + longint'(w.req_cpu_load))
                begin
                    r.status = ST_HOST_LD;
                    return r;
                end
                best = -1;
                best_sc = 0;
                for (int s = 0; s < DEVICE_SLOTS; s++)
                begin
                    if (!w.device_mask[s] || !slot_here[s]) continue;
                    fa = slot_free[s];
                    la = slot_load[s];
                    for (g = 0; g < GRANT_ENTRIES; g++)
                        if (gr_live[g] && gr_dev[g] == slot_id[s])
                        begin
                            fa -= gr_dmem[g];
                            la += gr_dload[g];
                        end
                    if (fa - longint'(dev_rsv) - longint'(w.req_device_mem) <= 0) continue;
                    if (!w.force_req &&
                        (100 - la < 10 || 100 - la - longint'(w.req_device_load) <= 0))
                        continue;
                    sc = place_score(fa, slot_total[s], la);
                    if (best < 0 || sc > best_sc)
                    begin
                        best = s;
                        best_sc = sc;
                    end
                end
                if (best < 0)
                begin
                    r.status = ST_NO_DEV;
                    return r;
                end
                r.status = ST_GRANTED;
                r.chosen_device = slot_id[best];
                free_g = -1;
                for (g = GRANT_ENTRIES - 1; g >= 0; g--)
                    if (!gr_live[g]) free_g = g;
                if (free_g < 0)
                begin
                    r.grants_full = 1'b1;
                    return r;
                end
                gr_live[free_g]  = 1'b1;
                gr_age[free_g]   = 16'd0;
                gr_dev[free_g]   = slot_id[best];
                gr_hmem[free_g]  = w.req_host_mem;
                gr_dmem[free_g]  = w.req_device_mem;
                gr_cpu[free_g]   = w.req_cpu_load;
                gr_dload[free_g] = w.req_device_load;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            host_rsv <= '0;
            dev_rsv  <= '0;
            lifetime <= 16'd10;
            cpus     <= 8'd1;
            host_free_mb <= '0;
            host_busy    <= '0;
            for (int i = 0; i < DEVICE_SLOTS; i++) slot_here[i] <= 1'b0;
            for (int i = 0; i < GRANT_ENTRIES; i++) gr_live[i] <= 1'b0;
            placement_q.delete();
            fail_count <= 0;
            checked <= 0;
            granted <= 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_HOST_RSV: host_rsv <= pwdata[19:0];
                    REG_DEV_RSV:  dev_rsv  <= pwdata[19:0];
                    REG_LIFETIME: lifetime <= pwdata[15:0];
                    default:      cpus     <= pwdata[7:0];
                endcase
            // predict each accepted input word
            if (push && !full)
                placement_q = {placement_q, place_word(in_word)};
            // compare each accepted result word
            if (pop && !empty)
            begin
                checked <= checked + 1;
                if (placement_q.size() == 0)
                begin
                    $error("result word with nothing expected: %p", out_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (want.status == ST_GRANTED) granted <= granted + 1;
                    if (out_word.status !== want.status)
                        $error("status: expected %0d, actual %0d", want.status, out_word.status);
                    if (out_word.chosen_device !== want.chosen_device)
                        $error("chosen_device: expected %0d, actual %0d",
                               want.chosen_device, out_word.chosen_device);
                    if (out_word.grants_full !== want.grants_full)
                        $error("grants_full: expected %0d, actual %0d",
                               want.grants_full, out_word.grants_full);
                    if (out_word !== want) fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
// Top of the placement engine testbench: clock, reset, stimulus, register
// writes and verdict. Depends on atp_pkg, atp_checker and the engine RTL.
module tb_top;
    import atp_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_word_t   in_word;
    logic       empty;
    logic       pop;
    out_word_t  out_word;
    logic       psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;
    int         fail_count, pending, checked, granted;
    int         words_sent;
    logic       hold_req;
    logic [7:0] id_pool [4];

    accelerator_task_placement i_dut (.*);

    atp_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, and one long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1, 2: stall = $urandom_range(1, 3);
                    3:       stall = $urandom_range(20, 120);
                    default: stall = 0;
                endcase
            end
        end
    end

    // send one word, with a random gap in front
    task automatic send_word(in_word_t w);
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 4);
            3:       gap = $urandom_range(20, 150);
            default: gap = 0;
        endcase
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        words_sent++;
    endtask

    // drain all results, then write one register
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic in_word_t make_word(logic [1:0] f);
        in_word_t w;
        logic [159:0] rnd_bits;
        rnd_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = rnd_bits[$bits(in_word_t)-1:0];
        w.func = f;
        w.load_pct = 7'($urandom_range(0, 100));
        w.req_device_load = 7'($urandom_range(0, 100));
        w.req_cpu_load = 15'($urandom_range(0, 25500));
        return w;
    endfunction

    function automatic in_word_t device_word(int s, logic [7:0] id, int tot, int fr, int ld);
        in_word_t w;
        w = make_word(FUNC_DEVICE);
        w.slot = 3'(s);
        w.dev_ident = id;
        w.total_mem = 20'(tot);
        w.free_mem = 20'(fr);
        w.load_pct = 7'(ld);
        return w;
    endfunction

    function automatic in_word_t host_word(int fr, int ld);
        in_word_t w;
        w = make_word(FUNC_HOST);
        w.free_mem = 20'(fr);
        w.load_pct = 7'(ld);
        return w;
    endfunction

    function automatic in_word_t req_word(int hm, int dm, int cpu, int dl, bit frc,
                                          logic [7:0] msk);
        in_word_t w;
        w = make_word(FUNC_REQUEST);
        w.req_host_mem = 20'(hm);
        w.req_device_mem = 20'(dm);
        w.req_cpu_load = 15'(cpu);
        w.req_device_load = 7'(dl);
        w.force_req = frc;
        w.device_mask = msk;
        return w;
    endfunction

    // well-formed random word: mostly plausible figures, sometimes raw
    function automatic in_word_t random_word();
        in_word_t w;
        int tot;
        bit raw;
        raw = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                w = make_word(FUNC_TICK);
            end
            2, 3:
            begin
                tot = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1000, 1048575);
                w = device_word($urandom_range(0, 7), id_pool[$urandom_range(0, 3)],
                                tot, $urandom_range(0, tot), $urandom_range(0, 60));
                if (raw) w = device_word(int'(w.slot), 8'($urandom), $urandom, $urandom,
                                         $urandom_range(0, 100));
            end
            4:
            begin
                w = host_word($urandom_range(100000, 1048575), $urandom_range(0, 60));
                if (raw) w = host_word($urandom, $urandom_range(0, 100));
            end
            default:
            begin
                w = req_word($urandom_range(0, 20000), $urandom_range(0, 60000),
                             $urandom_range(0, 150), $urandom_range(0, 20),
                             $urandom_range(0, 4) == 0, 8'($urandom));
                if (raw) w = make_word(FUNC_REQUEST);
            end
        endcase
        return w;
    endfunction

    initial
    begin
        logic [31:0] cfg_set [5][4];
        rst_n = 1'b0;
        push = 1'b0;
        in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        words_sent = 0;
        cfg_set = '{'{0, 0, 10, 1}, '{1048575, 1048575, 65535, 255},
                    '{5000, 20000, 0, 0}, '{0, 0, 3, 4}, '{20000, 1000, 40, 2}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every function, special cases
        send_word(make_word(FUNC_REQUEST));
        send_word(host_word(1048575, 0));
        send_word(device_word(0, 8'd0, 0, 1048575, 0));
        send_word(device_word(7, 8'd255, 1048575, 1048575, 100));
        send_word(device_word(3, 8'd17, 1000, 900, 50));
        send_word(device_word(4, 8'd17, 1000, 900, 50));
        send_word(req_word(1048575, 0, 0, 0, 0, 8'hFF));
        send_word(req_word(0, 0, 25500, 0, 0, 8'hFF));
        send_word(req_word(0, 0, 0, 0, 0, 8'h00));
        send_word(req_word(0, 0, 0, 0, 0, 8'h18));
        send_word(req_word(0, 1048575, 0, 0, 1, 8'hFF));
        send_word(req_word(0, 100, 0, 100, 1, 8'h80));
        send_word(req_word(0, 100, 0, 100, 1, 8'h80));
        send_word(req_word(0, 10, 100, 0, 0, 8'h01));
        send_word(req_word(0, 0, 0, 0, 1, 8'h66));
        for (int i = 0; i < 12; i++) send_word(make_word(FUNC_TICK));
        send_word(host_word(0, 100));
        send_word(req_word(0, 0, 0, 0, 1, 8'hFF));

        // random phases across register settings
        for (int p = 0; p < 5; p++)
        begin
            for (int r = 0; r < 4; r++) write_reg(r[1:0], cfg_set[p][r]);
            for (int i = 0; i < 4; i++) id_pool[i] = 8'($urandom);
            for (int s = 0; s < DEVICE_SLOTS; s++)
                send_word(device_word(s, id_pool[s % 4], 200000, 150000, 10));
            send_word(host_word(1000000, 5));
            if (p == 1) hold_req = 1'b1;
            for (int i = 0; i < 195; i++) send_word(random_word());
        end
        push <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("Sent %0d words over 5 register settings; checked %0d results, %0d grants.",
                 words_sent, checked, granted);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
